/* rtl/crts_pkg.sv */
// ----------------------------------------------------------------------------
// crts_pkg
// Shared types and constants of the crosspoint route table shifter.
// ----------------------------------------------------------------------------
package crts_pkg;

  localparam int LINES    = 32;
  localparam int LINE_W   = $clog2(LINES);
  localparam int CHUNKS   = 64;
  localparam int CNT_W    = $clog2(CHUNKS);
  localparam int CHUNK_W  = 16;
  localparam int MODE_W   = 3;
  localparam int KIND_W   = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 24;

  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LOAD_X = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LOAD_Y = 3'd6;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHUNK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SKIP  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec_go;
    logic flush_start;
    logic flush_sel;
    logic chunk_go;
  } cmd_t;

  typedef struct packed {
    logic is_flush;
    logic enabled;
    logic out_free;
    logic cnt_last;
  } stat_t;

endpackage

/* rtl/crts_ctrl.sv */
// ----------------------------------------------------------------------------
// crts_ctrl
// Sequencer: accepts an item, executes it, walks the chunks of a flush.
// ----------------------------------------------------------------------------
module crts_ctrl import crts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_flush && stat.enabled) begin
          cmd.flush_start = 1'b1;
          state_next      = ST_FLUSH;
        end else if (stat.out_free) begin
          cmd.exec_go = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        cmd.flush_sel = 1'b1;
        if (stat.out_free) begin
          cmd.chunk_go = 1'b1;
          if (stat.cnt_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/crts_dp.sv */
// ----------------------------------------------------------------------------
// crts_dp
// Datapath: line maps, route matrix, chunk counter and output register.
// ----------------------------------------------------------------------------
module crts_dp import crts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [IN_W-1:0]     in_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    out_data,
  output logic [KIND_W-1:0]   out_kind,
  output logic                out_last
);

  logic [LINES-1:0]  matrix [LINES];
  logic [LINE_W-1:0] x_map  [LINES];
  logic [LINE_W-1:0] y_map  [LINES];

  logic              enabled;
  logic [MODE_W-1:0] mode;
  logic [LINE_W-1:0] x_line;
  logic [LINE_W-1:0] y_line;
  logic [LINE_W-1:0] map_index;
  logic [LINE_W-1:0] map_value;
  logic [CNT_W-1:0]  cnt;

  logic              out_routed;
  logic [CHUNK_W-1:0] out_chunk;

  logic [LINE_W-1:0] px;
  logic [LINE_W-1:0] py;
  logic [LINE_W-1:0] frow;
  logic [LINE_W-1:0] rd_addr;
  logic [LINES-1:0]  row;
  logic [LINES-1:0]  bit_mask;
  logic              out_free;

  assign px       = x_map[x_line];
  assign py       = y_map[y_line];
  assign frow     = {~cnt[CNT_W-1], ~cnt[3:0]};
  assign rd_addr  = cmd.flush_sel ? frow : py;
  assign row      = matrix[rd_addr];
  assign bit_mask = LINES'(1) << px;
  assign out_free = !out_valid || out_ready;

  assign stat.is_flush = (mode == MODE_FLUSH);
  assign stat.enabled  = enabled;
  assign stat.out_free = out_free;
  assign stat.cnt_last = (cnt == CNT_W'(CHUNKS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_wr_en) begin
      enabled <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode      <= in_data[2:0];
      x_line    <= in_data[7:3];
      y_line    <= in_data[12:8];
      map_index <= in_data[17:13];
      map_value <= in_data[22:18];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        matrix[i] <= '0;
        x_map[i]  <= LINE_W'(i);
        y_map[i]  <= LINE_W'(i);
      end
    end else if (cmd.exec_go) begin
      case (mode)
        MODE_ADD:    matrix[py] <= row | bit_mask;
        MODE_REMOVE: matrix[py] <= row & ~bit_mask;
        MODE_CLEAR: begin
          for (int i = 0; i < LINES; i++) begin
            matrix[i] <= '0;
          end
        end
        MODE_LOAD_X: x_map[map_index] <= map_value;
        MODE_LOAD_Y: y_map[map_index] <= map_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.flush_start) begin
      cnt <= '0;
    end else if (cmd.chunk_go) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec_go || cmd.chunk_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chunk_go) begin
      out_kind   <= KIND_CHUNK;
      out_routed <= 1'b0;
      out_chunk  <= cnt[4] ? row[CHUNK_W-1:0] : row[LINES-1:CHUNK_W];
      out_last   <= stat.cnt_last;
    end else if (cmd.exec_go) begin
      out_routed <= 1'b0;
      out_chunk  <= '0;
      out_last   <= 1'b1;
      case (mode)
        MODE_QUERY: begin
          out_kind   <= KIND_QUERY;
          out_routed <= row[px];
        end
        MODE_FLUSH: out_kind <= KIND_SKIP;
        default:    out_kind <= KIND_ACK;
      endcase
    end
  end

  assign out_data = {{(OUT_W - CHUNK_W - 1){1'b0}}, out_chunk, out_routed};

endmodule

/* rtl/crosspoint_route_table_shifter_unit.sv */
// ----------------------------------------------------------------------------
// crosspoint_route_table_shifter_unit
// 32x32 crosspoint route matrix with x/y line maps and a serial flush.
// ----------------------------------------------------------------------------
// Items enter on s_axis; tdata carries mode, x_line, y_line, map_index and
// map_value. Results leave on m_axis: tuser is the result kind, tdata holds
// routed and chunk, tlast marks the final result of an item (for an enabled
// flush, the last chunk). cfg_wr_en/cfg_wr_data write the enable register.
// An item is accepted in the idle state and executed in the exec state once
// the output register is free; a single result is then registered in the
// output register. An enabled flush sends 64 chunks from the shared row read
// port, one per cycle while the receiver does not stall.
// s_axis_tready is low while an item is being executed or flushed.
// When the receiver stalls, the output register holds its item; execution
// and the flush walk pause until the register is free.
// Reset clears all routes, sets both maps to identity, clears enable and
// empties the output register; the block accepts items in the next cycle.
// ----------------------------------------------------------------------------
module crosspoint_route_table_shifter_unit import crts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // mode[2:0], x_line[7:3], y_line[12:8], map_index[17:13], map_value[22:18]
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // routed[0], chunk[16:1]
  output logic [OUT_W-1:0]  m_axis_tdata,
  // kind[1:0]
  output logic [KIND_W-1:0] m_axis_tuser,
  output logic              m_axis_tlast,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  crts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crts_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_kind    (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

endmodule

/* rtl/crts_check.sv */
// ----------------------------------------------------------------------------
// crts_check
// Port-level checks of the crosspoint route table shifter.
// ----------------------------------------------------------------------------
module crts_check import crts_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata,
  input logic [KIND_W-1:0] m_axis_tuser,
  input logic              m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != KIND_CHUNK) |-> m_axis_tlast)
    else $error("single result without last");

  a_chunk_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != KIND_CHUNK) |-> (m_axis_tdata[16:1] == '0))
    else $error("chunk bits set outside a flush");

  a_routed_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != KIND_QUERY) |-> !m_axis_tdata[0])
    else $error("routed set outside a query answer");

endmodule

bind crosspoint_route_table_shifter_unit crts_check u_check (.*);
